@@ rtl/pareto_front_selector_macros.svh @@
// Assertion macros used by the pareto front selector top level.
`ifndef PARETO_FRONT_SELECTOR_MACROS_SVH
`define PARETO_FRONT_SELECTOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define PFS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is high.
`define PFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define PFS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/pfs_pkg.sv @@
// Types and constants shared by the pareto front selector modules.
package pfs_pkg;

   localparam int TIME_W       = 31;
   localparam int SCORE_W      = 16;
   localparam int NUM_W        = 7;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 8;
   localparam int RSP_USER_W   = 2;
   localparam int USER_KEPT_BIT = 0;
   localparam int USER_OVFL_BIT = 1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // a request is accepted this cycle
      logic cand_rd;    // read the candidate entry from the store
      logic cand_cap;   // capture the candidate and restart the scan
      logic scan;       // step the comparison scan
      logic keep_k;     // remember the candidate as the newest kept item
      logic emit_prev;  // send the previously kept item as a non-final result
      logic next_k;     // move to the next candidate
      logic flush;      // send the closing result and clear the set
   } pfs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic kept;
      logic k_last;
      logic have_prev;
      logic out_free;
   } pfs_status_type;

endpackage

@@ rtl/pfs_datapath.sv @@
// Datapath: item store, comparison scan, kept-item buffer and result register.
module pfs_datapath #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pfs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tlast,
   input  pfs_pkg::pfs_cmd_type          cmd,
   output pfs_pkg::pfs_status_type       status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [pfs_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                          rsp_tlast
);
   import pfs_pkg::*;

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ITEMS);

   logic [TIME_W-1:0]  mem_time  [MAX_ITEMS];
   logic [SCORE_W-1:0] mem_score [MAX_ITEMS];
   logic [TIME_W-1:0]  rd_time_ff;
   logic [SCORE_W-1:0] rd_score_ff;
   logic [IW-1:0]      rd_addr;

   logic [CW-1:0]      count_ff, count_in;
   logic               ovfl_ff, ovfl_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      j_ff, j_in;
   logic               pend_ff, pend_in;
   logic [TIME_W-1:0]  cand_time_ff, cand_time_in;
   logic [SCORE_W-1:0] cand_score_ff, cand_score_in;
   logic [SCORE_W-1:0] earlier_max_ff, earlier_max_in;
   logic [SCORE_W-1:0] same_max_ff, same_max_in;
   logic [NUM_W-1:0]   prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   logic               out_valid_ff, out_valid_in;
   logic [NUM_W-1:0]   out_num_ff, out_num_in;
   logic               out_kept_ff, out_kept_in;
   logic               out_last_ff, out_last_in;
   logic               out_ovfl_ff, out_ovfl_in;

   logic               has_room;
   logic               issue;
   logic               out_free;
   logic [NUM_W-1:0]   k_number;

   assign has_room = count_ff < MAX_COUNT;
   assign issue    = cmd.scan && (j_ff < count_ff);
   assign out_free = !out_valid_ff || rsp_tready;
   assign k_number = NUM_W'(k_ff) + NUM_W'(1);
   assign rd_addr  = cmd.cand_rd ? k_ff[IW-1:0] : j_ff[IW-1:0];

   // Store: one write port for loading, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         mem_time[count_ff[IW-1:0]]  <= req_tdata[TIME_W-1:0];
         mem_score[count_ff[IW-1:0]] <= req_tdata[TIME_W+SCORE_W-1:TIME_W];
      end
      rd_time_ff  <= mem_time[rd_addr];
      rd_score_ff <= mem_score[rd_addr];
   end

   always_comb begin
      count_in       = count_ff;
      ovfl_in        = ovfl_ff;
      k_in           = k_ff;
      j_in           = j_ff;
      pend_in        = pend_ff;
      cand_time_in   = cand_time_ff;
      cand_score_in  = cand_score_ff;
      earlier_max_in = earlier_max_ff;
      same_max_in    = same_max_ff;
      prev_in        = prev_ff;
      have_prev_in   = have_prev_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_num_in     = out_num_ff;
      out_kept_in    = out_kept_ff;
      out_last_in    = out_last_ff;
      out_ovfl_in    = out_ovfl_ff;

      if (cmd.load) begin
         if (has_room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovfl_in = 1'b1;
         end
         if (req_tlast) begin
            k_in = '0;
         end
      end

      if (cmd.cand_cap) begin
         cand_time_in   = rd_time_ff;
         cand_score_in  = rd_score_ff;
         earlier_max_in = '0;
         same_max_in    = '0;
         j_in           = '0;
         pend_in        = 1'b0;
      end

      if (cmd.scan) begin
         pend_in = issue;
         if (issue) begin
            j_in = j_ff + CW'(1);
         end
         if (pend_ff) begin
            if (rd_time_ff < cand_time_ff) begin
               if (rd_score_ff > earlier_max_ff) begin
                  earlier_max_in = rd_score_ff;
               end
            end else if (rd_time_ff == cand_time_ff) begin
               if (rd_score_ff > same_max_ff) begin
                  same_max_in = rd_score_ff;
               end
            end
         end
      end

      if (cmd.emit_prev) begin
         out_valid_in = 1'b1;
         out_num_in   = prev_ff;
         out_kept_in  = 1'b1;
         out_last_in  = 1'b0;
         out_ovfl_in  = ovfl_ff;
      end

      if (cmd.keep_k) begin
         prev_in      = k_number;
         have_prev_in = 1'b1;
      end

      if (cmd.next_k) begin
         k_in = k_ff + CW'(1);
      end

      if (cmd.flush) begin
         out_valid_in = 1'b1;
         out_num_in   = have_prev_ff ? prev_ff : '0;
         out_kept_in  = have_prev_ff;
         out_last_in  = 1'b1;
         out_ovfl_in  = ovfl_ff;
         count_in     = '0;
         ovfl_in      = 1'b0;
         have_prev_in = 1'b0;
         k_in         = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovfl_ff      <= 1'b0;
         k_ff         <= '0;
         j_ff         <= '0;
         pend_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovfl_ff      <= ovfl_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         pend_ff      <= pend_in;
         have_prev_ff <= have_prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_time_ff   <= cand_time_in;
      cand_score_ff  <= cand_score_in;
      earlier_max_ff <= earlier_max_in;
      same_max_ff    <= same_max_in;
      prev_ff        <= prev_in;
      out_num_ff     <= out_num_in;
      out_kept_ff    <= out_kept_in;
      out_last_ff    <= out_last_in;
      out_ovfl_ff    <= out_ovfl_in;
   end

   // A candidate survives when it tops its own time and beats everything earlier, or is a zero score at time zero.
   assign status.kept = (cand_score_ff == same_max_ff) &&
                        ((cand_score_ff > earlier_max_ff) ||
                         ((cand_score_ff == '0) && (cand_time_ff == '0)));
   assign status.scan_done = !pend_ff && (j_ff == count_ff);
   assign status.k_last    = (k_ff == (count_ff - CW'(1)));
   assign status.have_prev = have_prev_ff;
   assign status.out_free  = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_num_ff);
   assign rsp_tlast  = out_last_ff;
   always_comb begin
      rsp_tuser                = '0;
      rsp_tuser[USER_KEPT_BIT] = out_kept_ff;
      rsp_tuser[USER_OVFL_BIT] = out_ovfl_ff;
   end

endmodule

@@ rtl/pfs_controller.sv @@
// Controller: sequences loading, per-candidate scans and result delivery.
module pfs_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   input  pfs_pkg::pfs_status_type status,
   output pfs_pkg::pfs_cmd_type    cmd
);
   import pfs_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD,
      S_CAND,
      S_CLOAD,
      S_SCAN,
      S_DECIDE,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = S_CAND;
            end
         end
         S_CAND: begin
            cmd.cand_rd = 1'b1;
            state_in    = S_CLOAD;
         end
         S_CLOAD: begin
            cmd.cand_cap = 1'b1;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // A new kept item pushes the held one out, which needs the output slot.
            if (!(status.kept && status.have_prev && !status.out_free)) begin
               cmd.keep_k    = status.kept;
               cmd.emit_prev = status.kept && status.have_prev;
               if (status.k_last) begin
                  state_in = S_FLUSH;
               end else begin
                  cmd.next_k = 1'b1;
                  state_in   = S_CAND;
               end
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/pareto_front_selector.sv @@
// Top level of the pareto front selector: controller, datapath and checks.
// Loading takes one request per cycle. After the request marked last, each of the N
// stored items is checked by a scan over all N entries of a single-read-port store.
// The next set is accepted once the closing result sits in the output register.
// Synchronous active-high reset empties the set and drops any pending result.
`include "pareto_front_selector_macros.svh"
module pareto_front_selector #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: time_value [30:0], score_value [46:31], zero pad [47].
   input  logic [pfs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,    // final_item
   // Result channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0: item_number [6:0], zero pad [7].
   output logic [pfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Fields from bit 0: any_kept [0], capacity_overflow [1].
   output logic [pfs_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                           rsp_tlast     // final_result
);
   import pfs_pkg::*;

   pfs_cmd_type    cmd;
   pfs_status_type status;
   logic           none_kept;

   // The controller walks the candidates one at a time and tells the datapath
   // when to load, read, scan and deliver.
   pfs_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the store, the running maxima for the current
   // candidate, one kept item held back so the last result can be marked,
   // and the output register.
   pfs_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A result is on offer that reports no kept item.
   assign none_kept = rsp_tvalid && !rsp_tuser[USER_KEPT_BIT];

   // While new requests are taken, only the closing result of the previous set may wait.
   `PFS_ASSERT_IMPL(a_load_only_after_close, clock, reset, req_tready && rsp_tvalid, rsp_tlast)
   // A result without a kept item is the single closing result and carries number zero.
   `PFS_ASSERT_IMPL(a_none_kept_form, clock, reset, none_kept, rsp_tlast && (rsp_tdata == '0))
   // A kept item always has a nonzero arrival number.
   `PFS_ASSERT_IMPL(a_kept_number, clock, reset, rsp_tvalid && rsp_tuser[USER_KEPT_BIT], rsp_tdata != '0)
   // The request marked last closes loading until the set has been evaluated.
   `PFS_ASSERT_NEXT(a_stop_after_last, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)

endmodule

@@ dv/pfs_front_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the kept-item numbers of each point set.
package pfs_front_check_pkg;
   import pfs_pkg::*;

   typedef struct packed {
      logic [NUM_W-1:0] item_number;
      logic             any_kept;
      logic             final_result;
      logic             capacity_overflow;
   } front_entry_type;

   class front_scoreboard;
      int                 capacity;
      bit [TIME_W-1:0]    set_times[$];
      bit [SCORE_W-1:0]   set_scores[$];
      bit                 overflowed;
      front_entry_type    expected_front[$];
      int                 mismatches;

      function new(int max_items);
         capacity    = max_items;
         overflowed  = 0;
         mismatches  = 0;
      endfunction

      // A point stays on the front when it holds the best score of its own time
      // and beats every earlier time, or when it is a zero score at time zero.
      function bit on_front(int k);
         bit [TIME_W-1:0]  t;
         bit [SCORE_W-1:0] s;
         bit [SCORE_W-1:0] earlier_best;
         bit [SCORE_W-1:0] same_best;
         t            = set_times[k];
         s            = set_scores[k];
         earlier_best = '0;
         same_best    = '0;
         foreach (set_times[j]) begin
            if (set_times[j] < t) begin
               if (set_scores[j] > earlier_best) earlier_best = set_scores[j];
            end else if (set_times[j] == t && set_scores[j] > same_best) begin
               same_best = set_scores[j];
            end
         end
         if (s != same_best) return 0;
         return (s > earlier_best) || (s == 0 && t == 0);
      endfunction

      function void note_request(bit [TIME_W-1:0] t, bit [SCORE_W-1:0] s, bit last);
         front_entry_type r;
         int              kept;
         if (set_times.size() < capacity) begin
            set_times.push_back(t);
            set_scores.push_back(s);
         end else begin
            overflowed = 1;
         end
         if (!last) return;
         kept = 0;
         foreach (set_times[k]) begin
            if (on_front(k)) begin
               r.item_number       = NUM_W'(k + 1);
               r.any_kept          = 1;
               r.final_result      = 0;
               r.capacity_overflow = overflowed;
               expected_front.push_back(r);
               kept++;
            end
         end
         if (kept == 0) begin
            r                   = '0;
            r.final_result      = 1;
            r.capacity_overflow = overflowed;
            expected_front.push_back(r);
         end else begin
            r = expected_front.pop_back();
            r.final_result = 1;
            expected_front.push_back(r);
         end
         set_times.delete();
         set_scores.delete();
         overflowed = 0;
      endfunction

      function void check_result(front_entry_type got);
         front_entry_type want;
         if (expected_front.size() == 0) begin
            $error("unexpected result: item_number %0d", got.item_number);
            mismatches++;
            return;
         end
         want = expected_front.pop_front();
         if (got.item_number !== want.item_number) begin
            $error("item_number: expected %0d, actual %0d", want.item_number, got.item_number);
            mismatches++;
         end
         if (got.any_kept !== want.any_kept) begin
            $error("any_kept: expected %0d, actual %0d", want.any_kept, got.any_kept);
            mismatches++;
         end
         if (got.final_result !== want.final_result) begin
            $error("final_result: expected %0d, actual %0d",
                   want.final_result, got.final_result);
            mismatches++;
         end
         if (got.capacity_overflow !== want.capacity_overflow) begin
            $error("capacity_overflow: expected %0d, actual %0d",
                   want.capacity_overflow, got.capacity_overflow);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_front.size();
      endfunction
   endclass

endpackage

@@ dv/pareto_front_selector_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the pareto front selector.
module pareto_front_selector_tb;
   import pfs_pkg::*;
   import pfs_front_check_pkg::*;

   localparam int MAX_ITEMS    = 64;
   localparam int ITEM_TARGET  = 320;
   // A full set scans all N entries for each of its N points. The run holds a few
   // full sets, a long receiver hold-off and small sets under heavy stalling, well
   // below this guard.
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 2500;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   rsp_tlast;

   // Idling phase: 0 = sender idles lightly and receiver heavily, 1 = the
   // reverse, 2 = neither side idles.
   logic [1:0]             idle_phase;
   logic                   hold_results;
   int                     requests_done;

   front_scoreboard        sb;

   pareto_front_selector #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int sender_idle_pct();
      case (idle_phase)
         2'd0: begin
            return 13;
         end
         2'd1: begin
            return 63;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_phase)
         2'd0: begin
            return 63;
         end
         2'd1: begin
            return 13;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   // Offers one request, with random idle cycles ahead of it, and hands it to
   // the scoreboard at the edge where it is accepted.
   task automatic send_request(bit [TIME_W-1:0] t, bit [SCORE_W-1:0] s, bit last);
      while ($urandom_range(99) < sender_idle_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, s, t};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(t, s, last);
      requests_done++;
      if (requests_done == ITEM_TARGET / 3) begin
         idle_phase <= 2'd1;
      end else if (requests_done == 2 * ITEM_TARGET / 3) begin
         idle_phase <= 2'd2;
      end
   endtask

   // Mostly narrow values so that times and scores collide often, with some
   // full-range values and the corners of both fields mixed in.
   function automatic bit [TIME_W-1:0] pick_time();
      int roll;
      roll = $urandom_range(9);
      if (roll < 7) return TIME_W'($urandom_range(15));
      if (roll < 9) return TIME_W'($urandom());
      return $urandom_range(1) ? '1 : '0;
   endfunction

   function automatic bit [SCORE_W-1:0] pick_score();
      int roll;
      roll = $urandom_range(9);
      if (roll < 7) return SCORE_W'($urandom_range(20));
      if (roll < 9) return SCORE_W'($urandom_range(65535));
      return $urandom_range(1) ? '1 : '0;
   endfunction

   // Sends one set of points. A rising staircase keeps most points on the
   // front and so produces long result bursts.
   task automatic send_point_set(int size, bit staircase);
      bit [TIME_W-1:0]  t;
      bit [SCORE_W-1:0] s;
      t = TIME_W'($urandom_range(3));
      s = SCORE_W'($urandom_range(3));
      for (int i = 0; i < size; i++) begin
         if (staircase) begin
            t = t + TIME_W'($urandom_range(3));
            s = s + SCORE_W'($urandom_range(3));
            send_request(t, s, i == size - 1);
         end else begin
            send_request(pick_time(), pick_score(), i == size - 1);
         end
      end
   endtask

   // Result side: checks every accepted result and stalls at random. The
   // long hold-off overrides the random pattern.
   initial begin
      front_entry_type got;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.item_number       = rsp_tdata[NUM_W-1:0];
            got.any_kept          = rsp_tuser[USER_KEPT_BIT];
            got.final_result      = rsp_tlast;
            got.capacity_overflow = rsp_tuser[USER_OVFL_BIT];
            sb.check_result(got);
         end
         rsp_tready <= !hold_results && ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // Once the sender stops idling, the receiver holds off long enough that a
   // finished set sits in the output register and the request side stalls.
   initial begin
      int stall_count;
      hold_results <= 1'b0;
      @(posedge clock);
      while (idle_phase != 2'd2) @(posedge clock);
      hold_results <= 1'b1;
      for (stall_count = 0; stall_count < HOLD_CYCLES; stall_count++) begin
         @(posedge clock);
      end
      hold_results <= 1'b0;
   end

   // Guard against a hung block.
   initial begin
      int cycle_count;
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
         @(posedge clock);
      end
      $error("run exceeded %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, sb.pending());
      $display("simulation failed");
      $finish;
   end

   initial begin
      int set_index;
      int set_size;
      sb            = new(MAX_ITEMS);
      requests_done = 0;
      reset         <= 1'b1;
      idle_phase    <= 2'd0;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tlast     <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A lone zero score at time zero is kept.
      send_request(0, 0, 1'b1);
      // A lone zero score at a later time is dropped, so the set reports none.
      send_request(5, 0, 1'b1);
      // Two equal points tie and are both beaten by a later-arriving earlier point.
      send_request(10, 5, 1'b0);
      send_request(10, 5, 1'b0);
      send_request(5, 7, 1'b1);
      // Field corners: the latest time is beaten by an equal score at time zero.
      send_request('1, '1, 1'b0);
      send_request(0, '1, 1'b1);
      // A zero score loses to a higher one at the same time; an equal score at
      // a later time is dropped.
      send_request(0, 0, 1'b0);
      send_request(0, 3, 1'b0);
      send_request(2, 3, 1'b0);
      send_request(1, 9, 1'b1);
      // Only the zero score at time zero survives among zero scores.
      send_request(3, 0, 1'b0);
      send_request(0, 0, 1'b0);
      send_request(7, 0, 1'b1);
      // Ties at one time that beat an earlier time, all four kept.
      send_request(20, 100, 1'b0);
      send_request(20, 100, 1'b0);
      send_request(19, 50, 1'b0);
      send_request(25, 200, 1'b1);

      // Random sets, mostly small, with one set past capacity, one that fills
      // the store exactly and one of middling size.
      set_index = 0;
      while (requests_done < ITEM_TARGET) begin
         case (set_index)
            2: begin
               send_point_set(MAX_ITEMS + $urandom_range(1, 5), 1'($urandom_range(1)));
            end
            6: begin
               send_point_set(MAX_ITEMS, 1'b1);
            end
            12: begin
               send_point_set($urandom_range(33, MAX_ITEMS - 1), 1'b0);
            end
            default: begin
               set_size = $urandom_range(1, 12);
               send_point_set(set_size, $urandom_range(3) == 0);
            end
         endcase
         set_index++;
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
